>>> hw/rtl/cdll_pkg.sv
// Shared codes, constants and control bundles for the linked-list engine.
package cdll_pkg;

  // Operation codes of a request
  localparam logic [1:0] FUNC_INS = 2'd0;
  localparam logic [1:0] FUNC_APP = 2'd1;
  localparam logic [1:0] FUNC_DEL = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Free-map memory row geometry
  localparam int ROW_BITS = 8;
  localparam int BIT_W    = 3;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 7;

  // Write enables of the three node arrays
  typedef struct packed {
    logic val;
    logic nxt;
    logic prv;
  } nm_we_t;

  // Commands to the free map
  typedef struct packed {
    logic alloc;
    logic release_slot;
  } fm_cmd_t;

  // Status from the free map
  typedef struct packed {
    logic ready;
    logic done;
  } fm_stat_t;

endpackage

>>> hw/rtl/cdll_ifs.sv
// Request and response channel interfaces of the linked-list engine.
interface cdll_req_if;
  import cdll_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface cdll_rsp_if;
  import cdll_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [TOTAL_W-1:0] node_total;

  modport source (output valid, output status, output node_total, input ready);
  modport sink (input valid, input status, input node_total, output ready);
endinterface

>>> hw/rtl/cdll_node_mem.sv
// Node storage: value, next link and previous link arrays with one read port.
module cdll_node_mem
  import cdll_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int SW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [SW-1:0]             rd_addr,
  output logic signed [VALUE_W-1:0] rd_value,
  output logic [SW-1:0]             rd_next,
  output logic [SW-1:0]             rd_prev,
  input  nm_we_t                    wr_en,
  input  logic [SW-1:0]             val_addr,
  input  logic signed [VALUE_W-1:0] val_data,
  input  logic [SW-1:0]             nxt_addr,
  input  logic [SW-1:0]             nxt_data,
  input  logic [SW-1:0]             prv_addr,
  input  logic [SW-1:0]             prv_data
);

  logic signed [VALUE_W-1:0] val_mem [DEPTH];
  logic [SW-1:0]             nxt_mem [DEPTH];
  logic [SW-1:0]             prv_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.val) begin
      val_mem[val_addr] <= val_data;
    end
    if (wr_en.nxt) begin
      nxt_mem[nxt_addr] <= nxt_data;
    end
    if (wr_en.prv) begin
      prv_mem[prv_addr] <= prv_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value <= val_mem[rd_addr];
      rd_next  <= nxt_mem[rd_addr];
      rd_prev  <= prv_mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/cdll_free_map.sv
// Free-slot map kept in a row memory: lowest-free allocation scan and release.
module cdll_free_map
  import cdll_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int SW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  fm_cmd_t       cmd,
  input  logic [SW-1:0] rel_slot,
  output fm_stat_t      stat,
  output logic [SW-1:0] alloc_slot
);

  localparam int ROWS = (DEPTH + ROW_BITS - 1) / ROW_BITS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [1:0] FM_CLEAR = 2'd0;
  localparam logic [1:0] FM_IDLE  = 2'd1;
  localparam logic [1:0] FM_SCAN  = 2'd2;
  localparam logic [1:0] FM_REL   = 2'd3;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd_row;

  logic [1:0]       state, state_next;
  logic [RW-1:0]    row, row_next;
  logic [BIT_W-1:0] rel_bit, rel_bit_next;

  logic                rd_en, wr_en;
  logic [RW-1:0]       rd_addr, wr_addr;
  logic [ROW_BITS-1:0] wr_data;
  logic [ROW_BITS-1:0] clr_mask;
  logic [BIT_W-1:0]    pick;
  logic                found;
  logic [SW+BIT_W-1:0] rel_ext;

  assign rel_ext = {{BIT_W{1'b0}}, rel_slot};
  assign found   = |rd_row;

  // Only bits that map onto real slots start out free
  always_comb begin
    for (int i = 0; i < ROW_BITS; i++) begin
      clr_mask[i] = (int'({row, BIT_W'(i)}) < DEPTH);
    end
  end

  // Lowest free bit of the scanned row
  always_comb begin
    pick = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (rd_row[i]) begin
        pick = BIT_W'(i);
      end
    end
  end

  assign alloc_slot = SW'({row, pick});
  assign stat.ready = (state == FM_IDLE);
  assign stat.done  = (state == FM_SCAN) && found;

  always_comb begin
    state_next   = state;
    row_next     = row;
    rel_bit_next = rel_bit;
    rd_en        = 1'b0;
    rd_addr      = row;
    wr_en        = 1'b0;
    wr_addr      = row;
    wr_data      = '0;
    unique case (state)
      FM_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = clr_mask;
        if (row == RW'(ROWS - 1)) begin
          row_next   = '0;
          state_next = FM_IDLE;
        end else begin
          row_next = row + 1'b1;
        end
      end
      FM_IDLE: begin
        if (cmd.alloc) begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          row_next   = '0;
          state_next = FM_SCAN;
        end else if (cmd.release_slot) begin
          rd_en        = 1'b1;
          rd_addr      = rel_ext[RW+BIT_W-1:BIT_W];
          row_next     = rel_ext[RW+BIT_W-1:BIT_W];
          rel_bit_next = rel_ext[BIT_W-1:0];
          state_next   = FM_REL;
        end
      end
      FM_SCAN: begin
        if (found) begin
          wr_en      = 1'b1;
          wr_data    = rd_row & ~(ROW_BITS'(1) << pick);
          state_next = FM_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = row + 1'b1;
          row_next = row + 1'b1;
        end
      end
      FM_REL: begin
        wr_en      = 1'b1;
        wr_data    = rd_row | (ROW_BITS'(1) << rel_bit);
        state_next = FM_IDLE;
      end
      default: begin
        state_next = FM_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FM_CLEAR;
      row   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
    end
    rel_bit <= rel_bit_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/circular_doubly_linked_list_engine_unit.sv
// Top level of the circular doubly linked list engine: sequencer and result register.
//
// Channel  Dir  Payload                         Handshake
// req      in   func[1:0], value[31:0] signed   valid/ready, taken when both high
// rsp      out  status[1:0], node_total[6:0]    valid/ready, taken when both high
//
// One request at a time. Insert or append: the free map scans its rows (8 slots
// each) from the first until it finds the lowest free slot, the node is written,
// and unless the list was empty it is spliced between tail and head in S_LINK.
// Delete: the walk starts at the head and visits one node per cycle through the
// node memory read port until a match or until every node is visited. Full, empty
// and unknown-code requests go straight to the result state.
// After reset the free map runs a clearing pass over all ceil(POOL_SLOTS/8) rows
// before the first request is taken.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only when its own result is ready.
module circular_doubly_linked_list_engine_unit
  import cdll_pkg::*;
#(
  parameter int POOL_SLOTS = 64
) (
  input logic      clk,
  input logic      rst,
  cdll_req_if.sink req,
  cdll_rsp_if.source rsp
);

  localparam int SW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  // Sequencer state
  logic [2:0]                state, state_next;
  logic [FUNC_W-1:0]         func_q, func_q_next;
  logic signed [VALUE_W-1:0] value_q, value_q_next;
  logic [SW-1:0]             head, head_next;
  logic [CW-1:0]             list_size, list_size_next;
  logic [SW-1:0]             cur, cur_next;
  logic [CW-1:0]             steps, steps_next;
  logic [SW-1:0]             tail, tail_next;
  logic [SW-1:0]             new_slot, new_slot_next;
  logic [STAT_W-1:0]         res_status, res_status_next;

  // Result register
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [TOTAL_W-1:0] out_total;
  logic               out_free;
  logic               out_load;

  // Node memory ports
  logic                      nm_rd_en;
  logic [SW-1:0]             nm_rd_addr;
  logic signed [VALUE_W-1:0] nm_rd_value;
  logic [SW-1:0]             nm_rd_next;
  logic [SW-1:0]             nm_rd_prev;
  nm_we_t                    nm_we;
  logic [SW-1:0]             nm_val_addr;
  logic signed [VALUE_W-1:0] nm_val_data;
  logic [SW-1:0]             nm_nxt_addr;
  logic [SW-1:0]             nm_nxt_data;
  logic [SW-1:0]             nm_prv_addr;
  logic [SW-1:0]             nm_prv_data;

  // Free map ports
  fm_cmd_t       fm_cmd;
  fm_stat_t      fm_stat;
  logic [SW-1:0] fm_alloc_slot;

  logic req_take;
  logic is_full;

  cdll_node_mem #(
    .DEPTH (POOL_SLOTS)
  ) u_node_mem (
    .clk      (clk),
    .rd_en    (nm_rd_en),
    .rd_addr  (nm_rd_addr),
    .rd_value (nm_rd_value),
    .rd_next  (nm_rd_next),
    .rd_prev  (nm_rd_prev),
    .wr_en    (nm_we),
    .val_addr (nm_val_addr),
    .val_data (nm_val_data),
    .nxt_addr (nm_nxt_addr),
    .nxt_data (nm_nxt_data),
    .prv_addr (nm_prv_addr),
    .prv_data (nm_prv_data)
  );

  cdll_free_map #(
    .DEPTH (POOL_SLOTS)
  ) u_free_map (
    .clk        (clk),
    .rst        (rst),
    .cmd        (fm_cmd),
    .rel_slot   (cur),
    .stat       (fm_stat),
    .alloc_slot (fm_alloc_slot)
  );

  // Take a request only between operations and once the free map is settled
  assign req.ready = (state == S_IDLE) && fm_stat.ready;
  assign req_take  = req.valid && req.ready;
  assign is_full   = (list_size == CW'(POOL_SLOTS));

  assign out_free = !out_valid || rsp.ready;
  assign out_load = (state == S_RESP) && out_free;

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.node_total = out_total;

  always_comb begin
    state_next      = state;
    func_q_next     = func_q;
    value_q_next    = value_q;
    head_next       = head;
    list_size_next  = list_size;
    cur_next        = cur;
    steps_next      = steps;
    tail_next       = tail;
    new_slot_next   = new_slot;
    res_status_next = res_status;
    nm_rd_en        = 1'b0;
    nm_rd_addr      = head;
    nm_we           = '0;
    nm_val_addr     = new_slot;
    nm_val_data     = value_q;
    nm_nxt_addr     = new_slot;
    nm_nxt_data     = head;
    nm_prv_addr     = new_slot;
    nm_prv_data     = tail;
    fm_cmd          = '0;

    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          func_q_next  = req.func;
          value_q_next = req.value;
          unique case (req.func)
            FUNC_INS, FUNC_APP: begin
              if (is_full) begin
                res_status_next = ST_FULL;
                state_next      = S_RESP;
              end else begin
                // Fetch the head node now to learn the tail while the scan runs
                fm_cmd.alloc = 1'b1;
                nm_rd_en     = 1'b1;
                nm_rd_addr   = head;
                state_next   = S_ALLOC;
              end
            end
            FUNC_DEL: begin
              if (list_size == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_RESP;
              end else begin
                nm_rd_en   = 1'b1;
                nm_rd_addr = head;
                cur_next   = head;
                steps_next = '0;
                state_next = S_WALK;
              end
            end
            default: begin
              // Unused code: no change, report ok
              res_status_next = ST_OK;
              state_next      = S_RESP;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (fm_stat.done) begin
          new_slot_next   = fm_alloc_slot;
          nm_we.val       = 1'b1;
          nm_we.nxt       = 1'b1;
          nm_we.prv       = 1'b1;
          nm_val_addr     = fm_alloc_slot;
          nm_nxt_addr     = fm_alloc_slot;
          nm_prv_addr     = fm_alloc_slot;
          res_status_next = ST_OK;
          if (list_size == '0) begin
            // First node links to itself and becomes the head
            nm_nxt_data    = fm_alloc_slot;
            nm_prv_data    = fm_alloc_slot;
            head_next      = fm_alloc_slot;
            list_size_next = CW'(1);
            state_next     = S_RESP;
          end else begin
            nm_nxt_data = head;
            nm_prv_data = nm_rd_prev;
            tail_next   = nm_rd_prev;
            state_next  = S_LINK;
          end
        end
      end
      S_LINK: begin
        // Splice the new node between tail and head
        nm_we.nxt      = 1'b1;
        nm_we.prv      = 1'b1;
        nm_nxt_addr    = tail;
        nm_nxt_data    = new_slot;
        nm_prv_addr    = head;
        nm_prv_data    = new_slot;
        list_size_next = list_size + 1'b1;
        if (func_q == FUNC_INS) begin
          head_next = new_slot;
        end
        state_next = S_RESP;
      end
      S_WALK: begin
        if (nm_rd_value == value_q) begin
          fm_cmd.release_slot = 1'b1;
          res_status_next     = ST_OK;
          state_next          = S_RESP;
          if (nm_rd_next == cur) begin
            // Only node: empty the list
            head_next      = '0;
            list_size_next = '0;
          end else begin
            nm_we.nxt      = 1'b1;
            nm_we.prv      = 1'b1;
            nm_nxt_addr    = nm_rd_prev;
            nm_nxt_data    = nm_rd_next;
            nm_prv_addr    = nm_rd_next;
            nm_prv_data    = nm_rd_prev;
            list_size_next = list_size - 1'b1;
            if (cur == head) begin
              head_next = nm_rd_next;
            end
          end
        end else if (CW'(steps + 1'b1) == list_size) begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_RESP;
        end else begin
          // Advance along the next link
          nm_rd_en   = 1'b1;
          nm_rd_addr = nm_rd_next;
          cur_next   = nm_rd_next;
          steps_next = steps + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      list_size <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      list_size <= list_size_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    func_q     <= func_q_next;
    value_q    <= value_q_next;
    cur        <= cur_next;
    steps      <= steps_next;
    tail       <= tail_next;
    new_slot   <= new_slot_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_status <= res_status;
      out_total  <= TOTAL_W'(list_size);
    end
  end

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    list_size <= CW'(POOL_SLOTS))
    else $error("node count exceeds pool");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    list_size == '0 |-> head == '0)
    else $error("empty list with nonzero head");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    fm_cmd.alloc |-> !is_full)
    else $error("allocation issued on a full pool");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_load && res_status == ST_FULL |-> is_full)
    else $error("full status with room left");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> steps < list_size)
    else $error("walk ran past the list");
`endif

endmodule

>>> tb/sv/tb_circular_doubly_linked_list_engine_unit.sv
// Self-checking testbench for the circular doubly linked list engine.
module tb_circular_doubly_linked_list_engine_unit;
  import cdll_pkg::*;

  localparam int POOL        = 64;
  localparam int SLOT_W      = $clog2(POOL);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_CAP   = 40;
  localparam int DRAIN_WAIT  = 100;

  // Unused operation code: the engine answers without touching the list
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  // Traffic shapes of the random part
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [TOTAL_W-1:0] total;
  } outcome_t;

  // A request whose outcome is typed in carries it here; all others use the predictor
  typedef struct {
    bit       pinned;
    outcome_t want;
  } pin_t;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    bit                        pinned;
    logic [STAT_W-1:0]         status;
    logic [TOTAL_W-1:0]        total;
  } dir_row_t;

  logic clk;
  logic rst;

  cdll_req_if req_ch ();
  cdll_rsp_if rsp_ch ();

  circular_doubly_linked_list_engine_unit #(.POOL_SLOTS(POOL)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of the list: node pool, head, length and free slots
  bit signed [VALUE_W-1:0] node_val [POOL];
  bit [SLOT_W-1:0]         node_nxt [POOL];
  bit [SLOT_W-1:0]         node_prv [POOL];
  bit [SLOT_W-1:0]         head_idx;
  int unsigned             live_nodes;
  bit [POOL-1:0]           slot_free;

  pin_t     pin_q [$];
  outcome_t pending_outcomes [$];

  int send_idle;
  int recv_idle;
  int mismatches;
  int cycles;
  int requests_taken;
  int responses_seen;
  int full_hits;
  int empty_hits;
  int miss_hits;
  int peak_nodes;

  // Directed walk: empty-list cases, value extremes, head/tail/middle/only-node deletes
  dir_row_t script [23] = '{
    '{FUNC_DEL, 32'sd0,           1'b1, ST_EMPTY,    7'd0},
    '{FUNC_NOP, 32'sd0,           1'b1, ST_OK,       7'd0},
    '{FUNC_INS, 32'sh7FFFFFFF,    1'b1, ST_OK,       7'd1},
    '{FUNC_INS, 32'sh80000000,    1'b0, ST_OK,       7'd0},
    '{FUNC_APP, -32'sd1,          1'b0, ST_OK,       7'd0},
    '{FUNC_APP, 32'sd0,           1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, 32'sd5,           1'b1, ST_NOTFOUND, 7'd4},
    '{FUNC_NOP, -32'sd1,          1'b1, ST_OK,       7'd4},
    '{FUNC_DEL, 32'sh80000000,    1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, 32'sd0,           1'b0, ST_OK,       7'd0},
    '{FUNC_INS, 32'sd7,           1'b0, ST_OK,       7'd0},
    '{FUNC_APP, 32'sd7,           1'b0, ST_OK,       7'd0},
    '{FUNC_INS, 32'sd1,           1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, 32'sd7,           1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, -32'sd1,          1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, 32'sh7FFFFFFF,    1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, 32'sd7,           1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, 32'sd1,           1'b1, ST_OK,       7'd0},
    '{FUNC_DEL, 32'sd1,           1'b1, ST_EMPTY,    7'd0},
    '{FUNC_APP, 32'sh55555555,    1'b1, ST_OK,       7'd1},
    '{FUNC_INS, 32'shAAAAAAAA,    1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, 32'sh55555555,    1'b0, ST_OK,       7'd0},
    '{FUNC_DEL, 32'shAAAAAAAA,    1'b1, ST_OK,       7'd0}
  };

  // Apply one request to the shadow list and return its status
  function automatic logic [STAT_W-1:0] apply_request(input logic [FUNC_W-1:0] f,
                                                      input logic signed [VALUE_W-1:0] v);
    logic [STAT_W-1:0] st;
    bit                found;
    bit [SLOT_W-1:0]   slot;
    bit [SLOT_W-1:0]   cur;
    bit [SLOT_W-1:0]   nx;
    bit [SLOT_W-1:0]   pv;
    bit [SLOT_W-1:0]   tl;
    st = ST_OK;
    case (f)
      FUNC_INS, FUNC_APP: begin
        found = 1'b0;
        slot  = '0;
        for (int i = 0; i < POOL && !found; i++) begin
          if (slot_free[i]) begin
            found = 1'b1;
            slot  = SLOT_W'(i);
          end
        end
        if (!found) begin
          st = ST_FULL;
        end else begin
          slot_free[slot] = 1'b0;
          node_val[slot]  = v;
          if (live_nodes == 0) begin
            node_nxt[slot] = slot;
            node_prv[slot] = slot;
            head_idx       = slot;
          end else begin
            tl                 = node_prv[head_idx];
            node_nxt[slot]     = head_idx;
            node_prv[slot]     = tl;
            node_nxt[tl]       = slot;
            node_prv[head_idx] = slot;
            if (f == FUNC_INS) begin
              head_idx = slot;
            end
          end
          live_nodes++;
        end
      end
      FUNC_DEL: begin
        if (live_nodes == 0) begin
          st = ST_EMPTY;
        end else begin
          st  = ST_NOTFOUND;
          cur = head_idx;
          for (int k = 0; k < live_nodes && st == ST_NOTFOUND; k++) begin
            if (node_val[cur] == v) begin
              st             = ST_OK;
              nx             = node_nxt[cur];
              pv             = node_prv[cur];
              slot_free[cur] = 1'b1;
              if (nx == cur) begin
                head_idx   = '0;
                live_nodes = 0;
              end else begin
                node_nxt[pv] = nx;
                node_prv[nx] = pv;
                if (cur == head_idx) begin
                  head_idx = nx;
                end
                live_nodes--;
              end
            end else begin
              cur = node_nxt[cur];
            end
          end
        end
      end
      default: ;
    endcase
    return st;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP) begin
      $display("[%0d] %s: got %0d, want %0d", cycles, what, got, want);
    end
    mismatches++;
  endtask

  // Present one request, idling the channel at random first; valid stays high on return
  task automatic push_request(input logic [FUNC_W-1:0] f, input logic signed [VALUE_W-1:0] v,
                              input bit pinned, input outcome_t want);
    pin_t p;
    p.pinned = pinned;
    p.want   = want;
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pin_q.push_back(p);
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Bursts that fill the pool, drain it, or mix; deletes mostly target live values
  task automatic run_random(input int quota);
    int                        counted;
    int                        burst_left;
    int                        mode;
    int                        roll;
    int unsigned               pos;
    bit [SLOT_W-1:0]           s;
    logic [FUNC_W-1:0]         f;
    logic signed [VALUE_W-1:0] v;
    outcome_t                  none;
    counted    = 0;
    burst_left = 0;
    mode       = MODE_MIX;
    none       = '0;
    while (counted < quota) begin
      if (burst_left == 0) begin
        mode       = $urandom_range(MODE_MIX, MODE_FILL);
        burst_left = $urandom_range(90, 20);
      end
      burst_left--;
      roll = $urandom_range(99);
      case (mode)
        MODE_FILL:  f = roll < 6 ? FUNC_DEL : roll < 8 ? FUNC_NOP : roll < 54 ? FUNC_INS : FUNC_APP;
        MODE_DRAIN: f = roll < 85 ? FUNC_DEL : roll < 87 ? FUNC_NOP : roll < 94 ? FUNC_INS : FUNC_APP;
        default:    f = roll < 45 ? FUNC_DEL : roll < 48 ? FUNC_NOP : roll < 74 ? FUNC_INS : FUNC_APP;
      endcase
      roll = $urandom_range(99);
      if (f == FUNC_DEL && live_nodes != 0 && roll < 75) begin
        pos = $urandom_range(live_nodes - 1);
        s   = head_idx;
        repeat (pos) s = node_nxt[s];
        v = node_val[s];
      end else if (roll < 60) begin
        // narrow range so that duplicates and hits are common
        v = $urandom_range(15);
        v = v - 8;
      end else if (roll < 80) begin
        case ($urandom_range(3))
          0:       v = 32'sh7FFFFFFF;
          1:       v = 32'sh80000000;
          2:       v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end else begin
        v = $urandom;
      end
      push_request(f, v, 1'b0, none);
      if (f != FUNC_NOP) begin
        counted++;
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  // Predict on every accepted request, check every accepted response
  always @(posedge clk) begin
    outcome_t model;
    outcome_t want;
    pin_t     pin;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        model.status = apply_request(req_ch.func, req_ch.value);
        model.total  = TOTAL_W'(live_nodes);
        pin          = pin_q.pop_front();
        pending_outcomes.push_back(pin.pinned ? pin.want : model);
        requests_taken++;
        if (model.status == ST_FULL) full_hits++;
        if (model.status == ST_EMPTY) empty_hits++;
        if (model.status == ST_NOTFOUND) miss_hits++;
        if (live_nodes > peak_nodes) peak_nodes = live_nodes;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        responses_seen++;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("response with no request outstanding", rsp_ch.status, 0);
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_ch.status !== want.status) begin
            report_mismatch("status", rsp_ch.status, want.status);
          end
          if (rsp_ch.node_total !== want.total) begin
            report_mismatch("node_total", rsp_ch.node_total, want.total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycles, pending_outcomes.size());
      $display("circular_doubly_linked_list_engine_unit: mismatch");
      $finish;
    end
  end

  initial begin
    outcome_t want;
    rst            = 1'b1;
    head_idx       = '0;
    live_nodes     = 0;
    slot_free      = '1;
    send_idle      = 29;
    recv_idle      = 71;
    mismatches     = 0;
    cycles         = 0;
    requests_taken = 0;
    responses_seen = 0;
    full_hits      = 0;
    empty_hits     = 0;
    miss_hits      = 0;
    peak_nodes     = 0;
    req_ch.valid  <= 1'b0;
    req_ch.func   <= FUNC_INS;
    req_ch.value  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      want.status = script[i].status;
      want.total  = script[i].total;
      push_request(script[i].func, script[i].value, script[i].pinned, want);
    end

    run_random(567);
    send_idle = 71;
    recv_idle = 29;
    run_random(567);
    send_idle = 0;
    recv_idle = 0;
    run_random(567);

    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) begin
      @(posedge clk);
    end
    // catch any stray response after the last expected one
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      report_mismatch("responses never returned", pending_outcomes.size(), 0);
    end

    $display("%0d requests, %0d responses; list peaked at %0d nodes", requests_taken,
             responses_seen, peak_nodes);
    $display("pool full %0d times, empty deletes %0d, misses %0d, mismatches %0d",
             full_hits, empty_hits, miss_hits, mismatches);
    if (mismatches == 0) begin
      $display("circular_doubly_linked_list_engine_unit: match");
    end else begin
      $display("circular_doubly_linked_list_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
